>>> rtl/core/pmstk_pkg.sv
package pmstk_pkg;

  // Field widths fixed by the item formats.
  localparam int CMD_W    = 2;
  localparam int SID_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;
  localparam int BASE_W   = 8;
  localparam int NS_W     = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Defaults for the top-level parameters.
  localparam int DEF_STORE_DEPTH   = 256;
  localparam int DEF_MAX_STACK_LEN = 64;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;

  // Input command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SHOW = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_NUM_STACKS = 2'd0;
  localparam logic [1:0] REG_LEN_FIRST  = 2'd1;
  localparam logic [1:0] REG_LEN_SECOND = 2'd2;
  localparam logic [1:0] REG_LEN_THIRD  = 2'd3;

  // Classified operation kinds handed from front to back.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SHOW = 2'd2,
    OP_BAD  = 2'd3
  } op_kind_t;

  // One classified operation: target region already resolved.
  typedef struct packed {
    op_kind_t              kind;
    logic [1:0]            sel;
    logic [BASE_W-1:0]     base;
    logic [LEN_W-1:0]      cap;
    logic [VAL_W-1:0]      value;
  } op_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic pop;
  } q_rd_t;

endpackage

>>> rtl/core/pmstk_front.sv
module pmstk_front
  import pmstk_pkg::*;
#(
  parameter int MAX_STACK_LEN = DEF_MAX_STACK_LEN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_addr,
  input  logic [LEN_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  q_full,
  output logic                  q_push,
  output op_t                   q_op
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_STACK_LEN);

  logic [NS_W-1:0]  num_stacks_r;
  logic [LEN_W-1:0] len_first_r;
  logic [LEN_W-1:0] len_second_r;
  logic [LEN_W-1:0] len_third_r;

  logic [CMD_W-1:0] cmd;
  logic [SID_W-1:0] sid;
  logic [NS_W-1:0]  ns;
  logic [LEN_W-1:0] l1, l2, l3;
  logic             bad;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_stacks_r <= 2'd3;
      len_first_r  <= 7'd64;
      len_second_r <= 7'd64;
      len_third_r  <= 7'd64;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_NUM_STACKS: num_stacks_r <= cfg_wdata[NS_W-1:0];
        REG_LEN_FIRST:  len_first_r  <= cfg_wdata;
        REG_LEN_SECOND: len_second_r <= cfg_wdata;
        REG_LEN_THIRD:  len_third_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective stack count and clamped capacities.
  always_comb begin
    ns = (num_stacks_r < 2'd2) ? 2'd2 : num_stacks_r;
    l1 = (len_first_r  > MAX_LEN) ? MAX_LEN : len_first_r;
    l2 = (len_second_r > MAX_LEN) ? MAX_LEN : len_second_r;
    l3 = (len_third_r  > MAX_LEN) ? MAX_LEN : len_third_r;
  end

  assign cmd = in_tdata[1:0];
  assign sid = in_tdata[3:2];
  assign bad = (cmd > CMD_SHOW) || (sid == 2'd0) || (sid > ns);

  // Classify the transaction and resolve its region.
  always_comb begin
    q_op.value = in_tdata[35:4];
    q_op.sel   = sid - 2'd1;
    q_op.kind  = bad ? OP_BAD : op_kind_t'(cmd);
    case (sid)
      2'd1: begin
        q_op.base = '0;
        q_op.cap  = l1;
      end
      2'd2: begin
        q_op.base = {1'b0, l1};
        q_op.cap  = l2;
      end
      default: begin
        q_op.base = {1'b0, l1} + {1'b0, l2};
        q_op.cap  = l3;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

>>> rtl/core/pmstk_queue.sv
module pmstk_queue
  import pmstk_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  op_t   push_op,
  output logic  full,
  input  q_rd_t rd_in,
  output logic  empty,
  output op_t   head_op
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  op_t              entry_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             do_pop;

  assign full    = (fill_r == CNT_W'(Q_DEPTH));
  assign empty   = (fill_r == '0);
  assign head_op = entry_r[rd_ptr_r];
  assign do_pop  = rd_in.pop && !empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if ((push && !full) && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !(push && !full)) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/pmstk_back.sv
module pmstk_back
  import pmstk_pkg::*;
#(
  parameter int STORE_DEPTH   = DEF_STORE_DEPTH,
  parameter int MAX_STACK_LEN = DEF_MAX_STACK_LEN
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  op_t                    op,
  output q_rd_t                  q_rd,
  input  logic                   q_empty,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [VAL_W-1:0]  mem [STORE_DEPTH];
  logic [VAL_W-1:0]  rdata_r;
  logic [LEN_W-1:0]  cnt_r [3];
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VAL_W-1:0]    out_data_r;
  logic                out_last_r;

  logic                slot_free;
  logic [LEN_W-1:0]    cur_cnt;
  logic                we, rd_en, cnt_we;
  logic [LEN_W-1:0]    cnt_wval;
  logic [BASE_W-1:0]   addr_sum;
  logic [AW-1:0]       mem_addr;
  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [VAL_W-1:0]    emit_data;
  logic                emit_last;
  logic                walk_last;

  // Address reduction modulo the store depth, a constant table.
  function automatic logic [AW-1:0] wrap_addr(input logic [BASE_W-1:0] a);
    logic [AW-1:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (a == BASE_W'(i)) begin
        r = AW'(i % STORE_DEPTH);
      end
    end
    return r;
  endfunction

  assign slot_free = !out_valid_r || out_tready;
  assign cur_cnt   = cnt_r[op.sel];
  assign mem_addr  = wrap_addr(addr_sum);
  assign walk_last = ((idx_r + 1'b1) == n_r);

  // Sequencer: execute one queued operation, walking the region on display.
  always_comb begin
    state_nxt   = state_r;
    q_rd.pop    = 1'b0;
    we          = 1'b0;
    rd_en       = 1'b0;
    cnt_we      = 1'b0;
    cnt_wval    = cur_cnt;
    addr_sum    = '0;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_data   = '0;
    emit_last   = 1'b1;
    idx_nxt     = idx_r;
    n_nxt       = n_r;
    base_nxt    = base_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty && slot_free) begin
          q_rd.pop = 1'b1;
          case (op.kind)
            OP_PUSH: begin
              emit = 1'b1;
              if (cur_cnt >= op.cap) begin
                emit_status = ST_FULL;
              end else begin
                we       = 1'b1;
                addr_sum = op.base + {1'b0, cur_cnt};
                cnt_we   = 1'b1;
                cnt_wval = cur_cnt + 1'b1;
              end
            end
            OP_POP: begin
              if (cur_cnt == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                cnt_we    = 1'b1;
                cnt_wval  = cur_cnt - 1'b1;
                rd_en     = 1'b1;
                addr_sum  = op.base + {1'b0, cur_cnt - 1'b1};
                idx_nxt   = '0;
                n_nxt     = 7'd1;
                base_nxt  = op.base;
                state_nxt = S_WAIT;
              end
            end
            OP_SHOW: begin
              if (cur_cnt == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                addr_sum  = op.base;
                idx_nxt   = '0;
                n_nxt     = cur_cnt;
                base_nxt  = op.base;
                state_nxt = S_WAIT;
              end
            end
            default: begin
              emit        = 1'b1;
              emit_status = ST_BAD;
            end
          endcase
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_data = rdata_r;
          emit_last = walk_last;
          if (walk_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt  = idx_r + 1'b1;
            rd_en    = 1'b1;
            addr_sum = base_r + {1'b0, idx_r + 1'b1};
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Shared store with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[mem_addr] <= op.value;
    end
    if (rd_en) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Control state and occupancy counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      cnt_r[2] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cnt_we) begin
        cnt_r[op.sel] <= cnt_wval;
      end
    end
  end

  // Walk bookkeeping.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    base_r <= base_nxt;
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_data_r   <= emit_data;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r, out_status_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= LEN_W'(MAX_STACK_LEN)) && (cnt_r[1] <= LEN_W'(MAX_STACK_LEN)) &&
    (cnt_r[2] <= LEN_W'(MAX_STACK_LEN)))
    else $error("stack occupancy above capacity limit");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_IDLE) && !out_valid_r || we && out_tready)
    else $error("store write while busy or output blocked");

  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == S_WAIT))
    else $error("read data not consumed in wait state");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("result produced while output register occupied");
`endif

endmodule

>>> rtl/core/partitioned_multi_stack.sv
// Two or three stacks sharing one memory in consecutive regions.
// Input channel in_*: one transaction is a push, pop or display aimed at
// one stack. Result channel out_*: one result per push or pop, one result
// per stored entry for a display (bottom to top, tlast on the final one),
// one result for an empty stack, a full stack, a bad stack number or an unknown command.
// Configuration port cfg_*: number of stacks and the three capacities, to be
// written only while the block is idle; the block itself does not enforce it.
// A push or an error result passes through the queue and the output
// register; a pop or a displayed entry also passes through the registered
// memory read, and a display delivers one entry per cycle while the
// receiver takes them. The back end can take the next queued operation
// directly after a push or an error; a pop or a display holds it in the wait
// state until its last result is out, paced by the memory's one read port.
// A two-entry queue lets the front accept while the back is busy.
// Reset clears the occupancy counts, the queue and the output register and
// loads 3 stacks of 64 entries; the memory itself is not cleared.
// When the receiver stalls, the result is held and the back end waits;
// the front keeps accepting until the queue fills.
module partitioned_multi_stack
  import pmstk_pkg::*;
#(
  parameter int STORE_DEPTH   = DEF_STORE_DEPTH,
  parameter int MAX_STACK_LEN = DEF_MAX_STACK_LEN
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_addr,
  input  logic [LEN_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata: command[1:0], stack_id[3:2], value[35:4], zero pad[39:36]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: status[1:0], data[33:2], zero pad[39:34]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  logic  q_full, q_push, q_empty;
  op_t   push_op, head_op;
  q_rd_t q_rd;

  pmstk_front #(
    .MAX_STACK_LEN (MAX_STACK_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  pmstk_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .rd_in   (q_rd),
    .empty   (q_empty),
    .head_op (head_op)
  );

  pmstk_back #(
    .STORE_DEPTH   (STORE_DEPTH),
    .MAX_STACK_LEN (MAX_STACK_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (head_op),
    .q_rd       (q_rd),
    .q_empty    (q_empty),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sim/partitioned_multi_stack_test.sv
`timescale 1ns / 1ps

module partitioned_multi_stack_test
  import pmstk_pkg::*;
();

  localparam int STORE_WORDS = DEF_STORE_DEPTH;
  localparam int MAX_LEN     = DEF_MAX_STACK_LEN;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IN_PAD_W    = IN_TDATA_W - CMD_W - SID_W - VAL_W;

  // Command code that the block must reject.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    data;
    logic                last;
  } stack_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [1:0]             cfg_addr   = '0;
  logic [LEN_W-1:0]       cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // Shadow of the block: configuration, occupancy and memory image.
  logic [NS_W-1:0]  ns_reg = 2'd3;
  logic [LEN_W-1:0] len_reg [1:3] = '{7'd64, 7'd64, 7'd64};
  logic [LEN_W-1:0] stack_fill [1:3] = '{7'd0, 7'd0, 7'd0};
  logic [VAL_W-1:0] mem_image [STORE_WORDS];
  bit               mem_written [STORE_WORDS] = '{default: 1'b0};

  stack_result_t expected_results [$];
  int fail_count     = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  partitioned_multi_stack i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("partitioned_multi_stack regression: fail");
      $finish;
    end
  end

  // Values of 0 and 1 in the stack-count register behave as two stacks.
  function automatic int active_stacks();
    return (ns_reg < 2) ? 2 : int'(ns_reg);
  endfunction

  function automatic int region_cap(input int sid);
    return (len_reg[sid] > MAX_LEN) ? MAX_LEN : int'(len_reg[sid]);
  endfunction

  function automatic int region_base(input int sid);
    if (sid == 1) return 0;
    if (sid == 2) return region_cap(1);
    return region_cap(1) + region_cap(2);
  endfunction

  function automatic bit is_rejected(input logic [CMD_W-1:0] cmd, input logic [SID_W-1:0] sid);
    return (cmd == CMD_UNKNOWN) || (sid == 0) || (int'(sid) > active_stacks());
  endfunction

  // True when a pop or display would read a memory word never written.
  function automatic bit touches_unwritten(input logic [CMD_W-1:0] cmd,
                                           input logic [SID_W-1:0] sid);
    int b;
    int n;
    int lo;
    if (is_rejected(cmd, sid) || cmd == CMD_PUSH) return 1'b0;
    n = int'(stack_fill[sid]);
    b = region_base(int'(sid));
    lo = (cmd == CMD_POP) ? n - 1 : 0;
    for (int i = lo; i < n; i++) begin
      if (!mem_written[(b + i) % STORE_WORDS]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic expect_result(input logic [STATUS_W-1:0] status,
                               input logic [VAL_W-1:0] data, input logic last);
    stack_result_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    expected_results.push_back(r);
  endtask

  // Apply one accepted command to the shadow and queue what it must produce.
  task automatic predict_stack_op(input logic [CMD_W-1:0] cmd, input logic [SID_W-1:0] sid,
                                  input logic [VAL_W-1:0] val);
    int b;
    int c;
    int n;
    int a;
    if (is_rejected(cmd, sid)) begin
      expect_result(ST_BAD, '0, 1'b1);
    end else begin
      b = region_base(int'(sid));
      c = region_cap(int'(sid));
      n = int'(stack_fill[sid]);
      if (cmd == CMD_PUSH) begin
        if (n >= c) begin
          expect_result(ST_FULL, '0, 1'b1);
        end else begin
          a = (b + n) % STORE_WORDS;
          mem_image[a] = val;
          mem_written[a] = 1'b1;
          stack_fill[sid] = LEN_W'(n + 1);
          expect_result(ST_OK, '0, 1'b1);
        end
      end else if (n == 0) begin
        expect_result(ST_EMPTY, '0, 1'b1);
      end else if (cmd == CMD_POP) begin
        stack_fill[sid] = LEN_W'(n - 1);
        expect_result(ST_OK, mem_image[(b + n - 1) % STORE_WORDS], 1'b1);
      end else begin
        for (int i = 0; i < n && i < MAX_LEN; i++) begin
          expect_result(ST_OK, mem_image[(b + i) % STORE_WORDS],
                        (i + 1 == n) || (i + 1 == MAX_LEN));
        end
      end
    end
  endtask

  // Offer one command and wait for its transaction. A read that would reach
  // an unwritten word is turned into a push on the same stack.
  task automatic send_stack_op(input logic [CMD_W-1:0] cmd, input logic [SID_W-1:0] sid,
                               input logic [VAL_W-1:0] val);
    logic [CMD_W-1:0] op;
    op = touches_unwritten(cmd, sid) ? CMD_PUSH : cmd;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{IN_PAD_W{1'b0}}, val, sid, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_stack_op(op, sid, val);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers while the block is idle.
  task automatic set_layout(input logic [LEN_W-1:0] ns, input logic [LEN_W-1:0] l1,
                            input logic [LEN_W-1:0] l2, input logic [LEN_W-1:0] l3);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_NUM_STACKS;
    cfg_wdata <= ns;
    @(posedge clk);
    ns_reg = ns[NS_W-1:0];
    cfg_addr  <= REG_LEN_FIRST;
    cfg_wdata <= l1;
    @(posedge clk);
    len_reg[1] = l1;
    cfg_addr  <= REG_LEN_SECOND;
    cfg_wdata <= l2;
    @(posedge clk);
    len_reg[2] = l2;
    cfg_addr  <= REG_LEN_THIRD;
    cfg_wdata <= l3;
    @(posedge clk);
    len_reg[3] = l3;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls plus a long hold-off whenever the token moves;
  // each result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d data %h last %0d",
                 $time, out_tdata[1:0], out_tdata[33:2], out_tlast);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tdata[33:2] !== want.data) begin
          $display("%0t: data mismatch, expected %h actual %h",
                   $time, want.data, out_tdata[33:2]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch, expected %0d actual %0d",
                   $time, want.last, out_tlast);
          fail_count++;
        end
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Reads from stacks that were never pushed.
  task automatic test_reset_empty();
    send_stack_op(CMD_POP, 2'd1, 32'h0);
    send_stack_op(CMD_SHOW, 2'd2, 32'h0);
    send_stack_op(CMD_SHOW, 2'd3, 32'h0);
    send_stack_op(CMD_POP, 2'd3, 32'h0);
  endtask

  // Extreme values through push, pop and display.
  task automatic test_push_pop_extremes();
    send_stack_op(CMD_PUSH, 2'd1, 32'h7fff_ffff);
    send_stack_op(CMD_PUSH, 2'd1, 32'h8000_0000);
    send_stack_op(CMD_PUSH, 2'd2, 32'h0000_0000);
    send_stack_op(CMD_PUSH, 2'd3, 32'hffff_ffff);
    send_stack_op(CMD_PUSH, 2'd2, 32'h5555_5555);
    send_stack_op(CMD_SHOW, 2'd1, 32'haaaa_aaaa);
    send_stack_op(CMD_POP, 2'd1, 32'h0);
    send_stack_op(CMD_POP, 2'd2, 32'h0);
    send_stack_op(CMD_SHOW, 2'd2, 32'h0);
  endtask

  // Stack number zero and the unknown command.
  task automatic test_bad_requests();
    send_stack_op(CMD_PUSH, 2'd0, 32'h1234_5678);
    send_stack_op(CMD_SHOW, 2'd0, 32'h0);
    send_stack_op(CMD_UNKNOWN, 2'd1, 32'hffff_ffff);
    send_stack_op(CMD_UNKNOWN, 2'd0, 32'h0);
  endtask

  // Two stacks, zero capacity, oversize capacity, lowered capacity.
  task automatic test_config_edges();
    set_layout(7'd2, 7'd3, 7'd0, 7'd127);
    send_stack_op(CMD_PUSH, 2'd3, 32'h0000_0001);
    send_stack_op(CMD_PUSH, 2'd2, 32'h0000_0002);
    send_stack_op(CMD_PUSH, 2'd1, 32'h0000_0003);
    send_stack_op(CMD_PUSH, 2'd1, 32'h0000_0004);
    send_stack_op(CMD_PUSH, 2'd1, 32'h0000_0005);
    send_stack_op(CMD_SHOW, 2'd1, 32'h0);
    set_layout(7'd0, 7'd64, 7'd64, 7'd64);
    send_stack_op(CMD_POP, 2'd3, 32'h0);
    set_layout(7'd3, 7'd1, 7'd64, 7'd127);
    send_stack_op(CMD_PUSH, 2'd1, 32'h0000_0006);
    send_stack_op(CMD_POP, 2'd3, 32'h0);
  endtask

  // Fill every region to capacity, overflow it and display it whole.
  task automatic test_fill_regions();
    set_layout(7'd3, 7'd64, 7'd64, 7'd64);
    for (int s = 1; s <= 3; s++) begin
      while (stack_fill[s] < region_cap(s)) send_stack_op(CMD_PUSH, SID_W'(s), pick_value());
      send_stack_op(CMD_PUSH, SID_W'(s), pick_value());
      send_stack_op(CMD_SHOW, SID_W'(s), 32'h0);
    end
  endtask

  // Mostly well-formed commands on valid stacks, some rejected ones.
  task automatic run_random_mix(input int count);
    int r;
    logic [CMD_W-1:0] cmd;
    logic [SID_W-1:0] sid;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        cmd = CMD_W'($urandom_range(0, 3));
        sid = 2'd0;
      end else if (r < 8) begin
        cmd = CMD_W'($urandom_range(0, 3));
        sid = (active_stacks() == 2) ? 2'd3 : 2'd0;
      end else if (r < 12) begin
        cmd = CMD_UNKNOWN;
        sid = SID_W'($urandom_range(0, 3));
      end else begin
        sid = SID_W'($urandom_range(1, active_stacks()));
        r = $urandom_range(99);
        cmd = (r < 50) ? CMD_PUSH : (r < 85) ? CMD_POP : CMD_SHOW;
      end
      send_stack_op(cmd, sid, pick_value());
    end
  endtask

  // Receiver holds off while commands keep coming, so the input backs up.
  task automatic test_output_stall();
    wait_drain();
    hold_token <= hold_token + 1;
    run_random_mix(30);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 31;
    recv_stall_pct = 49;
    test_reset_empty();
    test_push_pop_extremes();
    test_bad_requests();
    test_config_edges();
    test_fill_regions();
    set_layout(7'd3, 7'd64, 7'd64, 7'd64);
    run_random_mix(41);

    send_idle_pct  = 49;
    recv_stall_pct = 31;
    set_layout(7'd2, 7'd0, 7'd64, 7'd127);
    run_random_mix(41);
    test_output_stall();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_layout(7'd1, 7'd1, 7'd1, 7'd1);
    run_random_mix(41);
    set_layout(LEN_W'($urandom_range(0, 3)), LEN_W'($urandom_range(0, 127)),
               LEN_W'($urandom_range(0, 127)), LEN_W'($urandom_range(0, 127)));
    run_random_mix(41);

    wait_drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("partitioned_multi_stack regression: pass");
    end else begin
      $display("partitioned_multi_stack regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/pmstk_pkg.sv
rtl/core/pmstk_front.sv
rtl/core/pmstk_queue.sv
rtl/core/pmstk_back.sv
rtl/core/partitioned_multi_stack.sv
sim/partitioned_multi_stack_test.sv
